/* sv/lpc_pkg.sv */
// shared constants and types of the lidar polar to cartesian converter
package lpc_pkg;

  localparam int unsigned STEPS_PER_CIRCLE = 360000;
  localparam int unsigned AZ_SCALE = 10;

  // pi/2 in Q2.30, split as whole and fractional multiples of one step
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned SIN_Q = HALF_PI_Q30 / STEPS_PER_CIRCLE;
  localparam longint unsigned SIN_R = HALF_PI_Q30 % STEPS_PER_CIRCLE;
  localparam longint unsigned SIN_NRECIP = (64'd1 << 37) / STEPS_PER_CIRCLE;

  // polynomial divisors and their 2^32 reciprocals
  localparam int unsigned SIN_ITERS = 5;
  localparam logic [6:0] SIN_DIV [SIN_ITERS] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};
  localparam logic [31:0] SIN_RECIP [SIN_ITERS] = '{
    32'((64'd1 << 32) / 64'd110),
    32'((64'd1 << 32) / 64'd72),
    32'((64'd1 << 32) / 64'd42),
    32'((64'd1 << 32) / 64'd20),
    32'((64'd1 << 32) / 64'd6)
  };

  // stages of the sine unit: seven fixed plus three per polynomial step
  localparam int unsigned SIN_LAT = 7 + 3 * SIN_ITERS;

  // kind of an input word
  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_POINT = 1'b1
  } kind_e;

  typedef logic [18:0] angle_t;

  typedef struct packed {
    logic [14:0] mag;
    logic        neg;
  } trig_t;

  typedef struct packed {
    logic signed [18:0] az;
    logic signed [17:0] el;
  } corr_t;

endpackage

/* sv/lpc_corr_mem.sv */
// per-laser correction memory with reset-cleared entry valid bits
module lpc_corr_mem import lpc_pkg::*; #(
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  corr_t         wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output corr_t         rd_data_o
);

  corr_t            mem_q [DEPTH];
  logic [DEPTH-1:0] vld_q;
  corr_t            rd_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  // never-loaded lasers read as zero corrections
  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

/* sv/lpc_sine_unit.sv */
// pipelined fixed-point sine / cosine of one angle step
module lpc_sine_unit import lpc_pkg::*; (
  input  logic   clk_i,
  input  logic   en_i,
  input  logic   cos_i,
  input  angle_t angle_i,
  output trig_t  trig_o
);

  localparam logic [20:0] N1 = 21'(STEPS_PER_CIRCLE);
  localparam logic [20:0] N2 = 21'(2 * STEPS_PER_CIRCLE);
  localparam logic [20:0] N3 = 21'(3 * STEPS_PER_CIRCLE);
  localparam logic [18:0] N_A = 19'(STEPS_PER_CIRCLE);
  localparam logic [36:0] N_V = 37'(STEPS_PER_CIRCLE);
  localparam logic [30:0] ONE_Q30 = 31'(32'd1 << 30);
  localparam logic [31:0] HALF_LSB = 32'(32'd1 << 14);
  localparam logic [16:0] MAG_MAX = 17'd32767;

  // quadrant split
  logic [20:0] a_t;
  logic [20:0] a_rfull;
  logic [1:0]  a_ksin;
  logic [1:0]  a_k;
  logic [18:0] a_r;
  logic [18:0] a_f;
  logic [18:0] a_f_q;
  logic        a_neg_q;

  always_comb begin
    a_t = {angle_i, 2'b00};
    if (a_t >= N3) begin
      a_ksin  = 2'd3;
      a_rfull = a_t - N3;
    end else if (a_t >= N2) begin
      a_ksin  = 2'd2;
      a_rfull = a_t - N2;
    end else if (a_t >= N1) begin
      a_ksin  = 2'd1;
      a_rfull = a_t - N1;
    end else begin
      a_ksin  = 2'd0;
      a_rfull = a_t;
    end
    // cosine is the next quadrant with the same remainder
    a_k = a_ksin + {1'b0, cos_i};
    a_r = 19'(a_rfull);
    a_f = a_k[0] ? (N_A - a_r) : a_r;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_f_q   <= a_f;
      a_neg_q <= a_k[1];
    end
  end

  // angle in radians: whole part and remainder product
  logic [30:0] b_p_q;
  logic [36:0] b_v_q;
  logic        b_neg_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_p_q   <= 31'(64'(a_f_q) * SIN_Q);
      b_v_q   <= 37'(64'(a_f_q) * SIN_R);
      b_neg_q <= a_neg_q;
    end
  end

  // remainder divided by the step count through its reciprocal
  logic [18:0] c_q0_q;
  logic [36:0] c_v_q;
  logic [30:0] c_p_q;
  logic        c_neg_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q0_q  <= 19'((64'(b_v_q) * SIN_NRECIP) >> 37);
      c_v_q   <= b_v_q;
      c_p_q   <= b_p_q;
      c_neg_q <= b_neg_q;
    end
  end

  logic [36:0] d_rem;
  logic [18:0] d_qv;
  logic [30:0] d_x_q;
  logic        d_neg_q;

  always_comb begin
    d_rem = c_v_q - 37'(64'(c_q0_q) * 64'(STEPS_PER_CIRCLE));
    d_qv  = c_q0_q + 19'(d_rem >= N_V);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_x_q   <= c_p_q + 31'(d_qv);
      d_neg_q <= c_neg_q;
    end
  end

  // square of the angle
  logic [30:0] e_x_q;
  logic [31:0] e_x2_q;
  logic        e_neg_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e_x2_q  <= 32'((64'(d_x_q) * 64'(d_x_q)) >> 30);
      e_x_q   <= d_x_q;
      e_neg_q <= d_neg_q;
    end
  end

  logic [30:0] it_x  [SIN_ITERS+1];
  logic [31:0] it_x2 [SIN_ITERS+1];
  logic [30:0] it_u  [SIN_ITERS+1];
  logic        it_neg[SIN_ITERS+1];

  assign it_x[0]   = e_x_q;
  assign it_x2[0]  = e_x2_q;
  assign it_u[0]   = ONE_Q30;
  assign it_neg[0] = e_neg_q;

  // horner steps of the taylor series, three stages each
  for (genvar i = 0; i < SIN_ITERS; i++) begin : g_iter
    logic [31:0] p1_pr_q;
    logic [30:0] p1_x_q;
    logic [31:0] p1_x2_q;
    logic        p1_neg_q;
    logic [31:0] p2_q0_q;
    logic [31:0] p2_pr_q;
    logic [30:0] p2_x_q;
    logic [31:0] p2_x2_q;
    logic        p2_neg_q;
    logic [31:0] p3_rem;
    logic [31:0] p3_q;
    logic [30:0] p3_u_q;
    logic [30:0] p3_x_q;
    logic [31:0] p3_x2_q;
    logic        p3_neg_q;

    always_comb begin
      p3_rem = p2_pr_q - (p2_q0_q * 32'(SIN_DIV[i]));
      p3_q   = p2_q0_q + 32'(p3_rem >= 32'(SIN_DIV[i]));
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        p1_pr_q  <= 32'((64'(it_x2[i]) * 64'(it_u[i])) >> 30);
        p1_x_q   <= it_x[i];
        p1_x2_q  <= it_x2[i];
        p1_neg_q <= it_neg[i];
        p2_q0_q  <= 32'((64'(p1_pr_q) * 64'(SIN_RECIP[i])) >> 32);
        p2_pr_q  <= p1_pr_q;
        p2_x_q   <= p1_x_q;
        p2_x2_q  <= p1_x2_q;
        p2_neg_q <= p1_neg_q;
        p3_u_q   <= ONE_Q30 - 31'(p3_q);
        p3_x_q   <= p2_x_q;
        p3_x2_q  <= p2_x2_q;
        p3_neg_q <= p2_neg_q;
      end
    end

    assign it_x[i+1]   = p3_x_q;
    assign it_x2[i+1]  = p3_x2_q;
    assign it_u[i+1]   = p3_u_q;
    assign it_neg[i+1] = p3_neg_q;
  end

  logic [30:0] f_s_q;
  logic        f_neg_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f_s_q   <= 31'((64'(it_x[SIN_ITERS]) * 64'(it_u[SIN_ITERS])) >> 30);
      f_neg_q <= it_neg[SIN_ITERS];
    end
  end

  // round to q1.15 and saturate
  logic [16:0] g_round;
  logic [14:0] g_mag;
  trig_t       g_trig_q;

  always_comb begin
    g_round = 17'((32'(f_s_q) + HALF_LSB) >> 15);
    g_mag   = (g_round > MAG_MAX) ? 15'(MAG_MAX) : 15'(g_round);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      g_trig_q.mag <= g_mag;
      g_trig_q.neg <= f_neg_q && (g_mag != 15'd0);
    end
  end

  assign trig_o = g_trig_q;

endmodule

/* sv/lidar_point_polar_to_cartesian_top.sv */
// lidar return to cartesian point converter, top level
// a point word passes stage 1, stage 2, the sine units, stage m1 and the output register on its way to out_valid_o
// throughput: one word per cycle while the pipeline does not hold, loads and points alike; a load gives no output
// the whole pipeline holds only while a word waits in the output register under out_stall_i
// reset clears all valid flags and the per-laser entry flags, so every laser
// reads zero corrections until loaded; there is no clearing pass
module lidar_point_polar_to_cartesian_top import lpc_pkg::*; #(
  parameter int unsigned LASER_COUNT = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               kind_i,
  input  logic [6:0]         laser_index_i,
  input  logic [15:0]        raw_azimuth_i,
  input  logic [23:0]        radius_i,
  input  logic [7:0]         intensity_i,
  input  logic signed [18:0] azimuth_correction_i,
  input  logic signed [17:0] elevation_correction_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [24:0] x_pos_o,
  output logic signed [24:0] y_pos_o,
  output logic signed [24:0] z_pos_o,
  output logic [18:0]        azimuth_out_o,
  output logic signed [17:0] elevation_out_o,
  output logic [7:0]         intensity_out_o,
  output logic               index_error_o
);

  localparam int unsigned AW = (LASER_COUNT > 1) ? $clog2(LASER_COUNT) : 1;
  localparam logic signed [20:0] N_S  = 21'(STEPS_PER_CIRCLE);
  localparam logic signed [20:0] N2_S = 21'(2 * STEPS_PER_CIRCLE);
  localparam logic [63:0] RND_Z  = 64'd1 << 14;
  localparam logic [63:0] RND_XY = 64'd1 << 29;

  typedef struct packed {
    logic               err;
    logic [23:0]        radius;
    logic [7:0]         intensity;
    angle_t             az;
    logic signed [17:0] el_raw;
  } side_t;

  logic          adv;
  logic          in_acc;
  logic          pt_acc;
  logic          ld_acc;
  logic          in_range;
  logic [AW-1:0] addr;
  corr_t         rd_corr;

  logic out_vld_q;

  // the pipe moves unless a finished word is held
  assign adv        = !out_vld_q || !out_stall_i;
  assign in_stall_o = !adv;
  assign in_acc     = in_valid_i && adv;
  assign in_range   = 9'(laser_index_i) < 9'(LASER_COUNT);
  assign pt_acc     = in_acc && (kind_i == KIND_POINT);
  assign ld_acc     = in_acc && (kind_i == KIND_LOAD) && in_range;
  assign addr       = AW'({1'b0, laser_index_i});

  lpc_corr_mem #(
    .DEPTH(LASER_COUNT)
  ) u_corr_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (ld_acc),
    .wr_addr_i(addr),
    .wr_data_i({azimuth_correction_i, elevation_correction_i}),
    .rd_en_i  (pt_acc),
    .rd_addr_i(addr),
    .rd_data_o(rd_corr)
  );

  // stage 1: point fields wait beside the memory read
  logic        s1_vld_q;
  logic        s1_err_q;
  logic [15:0] s1_raw_q;
  logic [23:0] s1_rad_q;
  logic [7:0]  s1_int_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= pt_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_err_q <= !in_range;
      s1_raw_q <= raw_azimuth_i;
      s1_rad_q <= radius_i;
      s1_int_q <= intensity_i;
    end
  end

  // stage 2: calibrated azimuth and elevation wrapped into one circle
  logic [19:0]        raw10;
  logic signed [20:0] az_sum;
  logic signed [20:0] el_sum;
  angle_t             az_w;
  angle_t             el_w;

  always_comb begin
    raw10  = 20'(s1_raw_q) * 20'(AZ_SCALE);
    az_sum = $signed({1'b0, raw10}) + 21'(rd_corr.az);
    if (az_sum < 21'sd0) begin
      az_w = 19'(az_sum + N_S);
    end else if (az_sum >= N2_S) begin
      az_w = 19'(az_sum - N2_S);
    end else if (az_sum >= N_S) begin
      az_w = 19'(az_sum - N_S);
    end else begin
      az_w = 19'(az_sum);
    end
    el_sum = 21'(rd_corr.el);
    el_w   = (el_sum < 21'sd0) ? 19'(el_sum + N_S) : 19'(el_sum);
  end

  logic [SIN_LAT:0] sb_vld_q;
  side_t            sb_q [SIN_LAT+1];
  angle_t           el_ang_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb_vld_q <= '0;
    end else if (adv) begin
      sb_vld_q <= {sb_vld_q[SIN_LAT-1:0], s1_vld_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sb_q[0].err       <= s1_err_q;
      sb_q[0].radius    <= s1_rad_q;
      sb_q[0].intensity <= s1_int_q;
      sb_q[0].az        <= az_w;
      sb_q[0].el_raw    <= rd_corr.el;
      el_ang_q          <= el_w;
      for (int i = 1; i <= SIN_LAT; i++) begin
        sb_q[i] <= sb_q[i-1];
      end
    end
  end

  trig_t sin_az;
  trig_t cos_az;
  trig_t sin_el;
  trig_t cos_el;

  lpc_sine_unit u_sin_az (
    .clk_i  (clk_i),
    .en_i   (adv),
    .cos_i  (1'b0),
    .angle_i(sb_q[0].az),
    .trig_o (sin_az)
  );

  lpc_sine_unit u_cos_az (
    .clk_i  (clk_i),
    .en_i   (adv),
    .cos_i  (1'b1),
    .angle_i(sb_q[0].az),
    .trig_o (cos_az)
  );

  lpc_sine_unit u_sin_el (
    .clk_i  (clk_i),
    .en_i   (adv),
    .cos_i  (1'b0),
    .angle_i(el_ang_q),
    .trig_o (sin_el)
  );

  lpc_sine_unit u_cos_el (
    .clk_i  (clk_i),
    .en_i   (adv),
    .cos_i  (1'b1),
    .angle_i(el_ang_q),
    .trig_o (cos_el)
  );

  // stage m1: angle products and the rounded z magnitude
  logic        m1_vld_q;
  side_t       m1_side_q;
  logic [29:0] m1_cs_q;
  logic [29:0] m1_cc_q;
  logic [24:0] m1_z_q;
  logic        m1_negx_q;
  logic        m1_negy_q;
  logic        m1_negz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_vld_q <= 1'b0;
    end else if (adv) begin
      m1_vld_q <= sb_vld_q[SIN_LAT];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1_side_q <= sb_q[SIN_LAT];
      m1_cs_q   <= 30'(cos_el.mag) * 30'(sin_az.mag);
      m1_cc_q   <= 30'(cos_el.mag) * 30'(cos_az.mag);
      m1_z_q    <= 25'((64'(sb_q[SIN_LAT].radius) * 64'(sin_el.mag) + RND_Z) >> 15);
      m1_negx_q <= cos_el.neg != sin_az.neg;
      m1_negy_q <= cos_el.neg != cos_az.neg;
      m1_negz_q <= sin_el.neg;
    end
  end

  // output register: radius times the angle products, signed; all zero for a bad laser index
  logic [24:0] x_mag;
  logic [24:0] y_mag;
  logic [24:0] x_q;
  logic [24:0] y_q;
  logic [24:0] z_q;
  angle_t      az_q;
  logic [17:0] el_q;
  logic [7:0]  int_q;
  logic        err_q;

  always_comb begin
    x_mag = 25'((64'(m1_side_q.radius) * 64'(m1_cs_q) + RND_XY) >> 30);
    y_mag = 25'((64'(m1_side_q.radius) * 64'(m1_cc_q) + RND_XY) >> 30);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= m1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      int_q <= m1_side_q.intensity;
      err_q <= m1_side_q.err;
      if (m1_side_q.err) begin
        x_q  <= '0;
        y_q  <= '0;
        z_q  <= '0;
        az_q <= '0;
        el_q <= '0;
      end else begin
        x_q  <= m1_negx_q ? (25'd0 - x_mag) : x_mag;
        y_q  <= m1_negy_q ? (25'd0 - y_mag) : y_mag;
        z_q  <= m1_negz_q ? (25'd0 - m1_z_q) : m1_z_q;
        az_q <= m1_side_q.az;
        el_q <= m1_side_q.el_raw;
      end
    end
  end

  assign out_valid_o     = out_vld_q;
  assign x_pos_o         = x_q;
  assign y_pos_o         = y_q;
  assign z_pos_o         = z_q;
  assign azimuth_out_o   = az_q;
  assign elevation_out_o = el_q;
  assign intensity_out_o = int_q;
  assign index_error_o   = err_q;

  // a load word never enters the result pipe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (kind_i == KIND_LOAD) |=> !s1_vld_q)
    else $error("load word entered the point pipeline");

  // the input is held back only by a waiting output word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> !in_stall_o)
    else $error("input stalled with an empty output register");

  // a bad laser index gives an all-zero point
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && index_error_o |-> (x_pos_o == '0) && (y_pos_o == '0) &&
      (z_pos_o == '0) && (azimuth_out_o == '0) && (elevation_out_o == '0))
    else $error("index error word carries nonzero fields");

  // the calibrated azimuth stays inside one circle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> azimuth_out_o < 19'(STEPS_PER_CIRCLE))
    else $error("azimuth out of range");

endmodule
